// ===== sv/rim_pkg.sv =====
// ----------------------------------------------------------------------------
// rim_pkg
// Shared constants and types for the utility maximum block.
// ----------------------------------------------------------------------------
package rim_pkg;

  localparam int MAX_OBJECTIVES = 8;
  localparam int VEC_SLOTS      = 64;
  localparam int FRAC_BITS      = 16;
  localparam int OBJ_W          = $clog2(MAX_OBJECTIVES);
  localparam int VEC_W          = $clog2(VEC_SLOTS);

  // divider geometry: |diff| is 33 bits, shifted left by FRAC_BITS
  localparam int DVD_W = 33 + FRAC_BITS;
  localparam int DVS_W = 33;

  // shared multiplier geometry
  localparam int MA_W = 18;
  localparam int MB_W = 38;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [MA_W-1:0] RHO_FIX = MA_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic [2:0] MODE_WEIGHT = 3'd0;
  localparam logic [2:0] MODE_BOUNDS = 3'd1;
  localparam logic [2:0] MODE_COORD  = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_EMIT   = 3'd4;

  localparam logic [1:0] UK_WSUM = 2'd0;
  localparam logic [1:0] UK_TCH  = 2'd1;

  localparam logic [1:0] REG_KIND = 2'd0;
  localparam logic [1:0] REG_OBJ  = 2'd1;
  localparam logic [1:0] REG_WGT  = 2'd2;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_NORM  = 11'b000_0000_0010,
    ST_DIV   = 11'b000_0000_0100,
    ST_WRD   = 11'b000_0000_1000,
    ST_MUL   = 11'b000_0001_0000,
    ST_ACC   = 11'b000_0010_0000,
    ST_RHO   = 11'b000_0100_0000,
    ST_UPD   = 11'b000_1000_0000,
    ST_ERD   = 11'b001_0000_0000,
    ST_ESEND = 11'b010_0000_0000,
    ST_EHOLD = 11'b100_0000_0000
  } state_t;

endpackage

// ===== sv/r_indicator_utility_max.sv =====
// ----------------------------------------------------------------------------
// r_indicator_utility_max
// Weighted utility running maximum over points, per weight vector.
// ----------------------------------------------------------------------------
//  channel | signals                                              | dir
//  in      | in_valid in_ready mode vector_index objective_index   | in
//          | value second_value                                   |
//  out     | out_valid out_ready out_vector best_utility any_point  | out
//          | last                                                 |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data                 | in
//
// Loads, clears and non-final coordinates are taken in ST_IDLE. A final
// coordinate runs ST_NORM per objective, plus ST_DIV for the serial divider
// on a nonzero span, then ST_WRD, ST_MUL, ST_ACC per weight and objective and
// ST_RHO, ST_UPD per weight for the shared multiplier. Emit runs ST_ERD,
// ST_ESEND, ST_EHOLD per result plus output stall. in_ready is low while
// busy. Reset clears control state and the running maxima valid bits.
module r_indicator_utility_max (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [5:0]         vector_index,
  input  logic [2:0]         objective_index,
  input  logic signed [31:0] value,
  input  logic signed [31:0] second_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_vector,
  output logic signed [31:0] best_utility,
  output logic               any_point,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rim_pkg::*;

  state_t state;

  logic [1:0] utility_kind;
  logic [3:0] objectives_in_use;
  logic [6:0] weights_in_use;
  logic [OBJ_W-1:0] obj_last;
  logic [VEC_W-1:0] vec_last;

  logic signed [31:0] ideal_r [MAX_OBJECTIVES];
  logic signed [31:0] nadir_r [MAX_OBJECTIVES];
  logic signed [31:0] point_r [MAX_OBJECTIVES];
  logic signed [31:0] norm_r  [MAX_OBJECTIVES];

  logic [16:0] weight_mem [VEC_SLOTS*MAX_OBJECTIVES];
  logic [16:0] weight_rdata;
  logic signed [31:0] rm_mem [VEC_SLOTS];
  logic signed [31:0] rm_rdata;
  logic [VEC_SLOTS-1:0] rm_valid;
  logic point_seen;

  logic [OBJ_W-1:0] oi;
  logic [VEC_W-1:0] wi;
  logic signed [35:0] sum;
  logic signed [31:0] mx;

  logic in_acc;
  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // effective register values, clamped
  always_comb begin
    if (objectives_in_use == 4'd0)
      obj_last = '0;
    else if (objectives_in_use > 4'(MAX_OBJECTIVES))
      obj_last = OBJ_W'(MAX_OBJECTIVES - 1);
    else
      obj_last = OBJ_W'(objectives_in_use - 4'd1);
    if (weights_in_use == 7'd0)
      vec_last = '0;
    else if (weights_in_use > 7'(VEC_SLOTS))
      vec_last = VEC_W'(VEC_SLOTS - 1);
    else
      vec_last = VEC_W'(weights_in_use - 7'd1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      utility_kind      <= 2'd2;
      objectives_in_use <= 4'd2;
      weights_in_use    <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KIND: utility_kind      <= cfg_data[1:0];
        REG_OBJ:  objectives_in_use <= cfg_data[3:0];
        REG_WGT:  weights_in_use    <= cfg_data[6:0];
        default:  ;
      endcase
    end
  end

  // normalization operands
  logic signed [32:0] diff, span;
  logic [33:0] abs_diff, abs_span;
  logic q_neg;
  logic div_start, div_done;
  logic [DVD_W-1:0] div_q;
  logic signed [31:0] norm_sat;
  logic signed [31:0] norm_zero;

  assign diff     = 33'(point_r[oi]) - 33'(ideal_r[oi]);
  assign span     = 33'(nadir_r[oi]) - 33'(ideal_r[oi]);
  assign abs_diff = diff[32] ? -34'(diff) : 34'(diff);
  assign abs_span = span[32] ? -34'(span) : 34'(span);
  assign q_neg    = diff[32] ^ span[32];
  assign div_start = (state == ST_NORM) && (span != '0);

  // saturate the signed quotient
  always_comb begin
    if (q_neg)
      norm_sat = (div_q > DVD_W'(33'h0_8000_0000)) ? S32_MIN : -32'(div_q);
    else
      norm_sat = (div_q > DVD_W'(33'h0_7FFF_FFFF)) ? S32_MAX : 32'(div_q);
    if (diff > 0)
      norm_zero = S32_MAX;
    else if (diff < 0)
      norm_zero = S32_MIN;
    else
      norm_zero = '0;
  end

  rim_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({abs_diff[32:0], FRAC_BITS'(0)}),
    .divisor  (abs_span[32:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared multiplier operands
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;
  logic signed [36:0] wu;
  logic signed [32:0] tu;
  logic signed [31:0] term;

  assign wu   = 37'sd65536 - 37'(sum);
  assign tu   = 33'sd65536 - 33'(mx);
  assign term = prod[47:16];

  always_comb begin
    if (state == ST_RHO) begin
      mul_a = RHO_FIX;
      mul_b = 38'(wu);
    end else begin
      mul_a = {1'b0, weight_rdata};
      mul_b = 38'(norm_r[oi]);
    end
  end

  rim_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // final utility
  logic signed [39:0] u_full;
  logic signed [31:0] u_sat;
  logic signed [31:0] rm_cur;

  always_comb begin
    case (utility_kind)
      UK_WSUM: u_full = 40'(wu);
      UK_TCH:  u_full = 40'(tu);
      default: u_full = 40'(tu) + 40'(prod[MP_W-1:FRAC_BITS]);
    endcase
    if (u_full > 40'(S32_MAX))
      u_sat = S32_MAX;
    else if (u_full < 40'(S32_MIN))
      u_sat = S32_MIN;
    else
      u_sat = 32'(u_full);
    rm_cur = rm_valid[wi] ? rm_rdata : S32_MIN;
  end

  // memories: weights and running maxima
  logic [16:0] w_clamp;
  always_comb begin
    if (value < 0)
      w_clamp = '0;
    else if (value > 32'(WEIGHT_ONE))
      w_clamp = WEIGHT_ONE;
    else
      w_clamp = 17'(value);
  end

  always_ff @(posedge clk) begin
    if (in_acc && mode == MODE_WEIGHT)
      weight_mem[{vector_index, objective_index}] <= w_clamp;
    weight_rdata <= weight_mem[{wi, oi}];
    if (state == ST_UPD && u_sat > rm_cur)
      rm_mem[wi] <= u_sat;
    rm_rdata <= rm_mem[wi];
  end

  // small stores
  always_ff @(posedge clk) begin
    if (in_acc && mode == MODE_BOUNDS) begin
      ideal_r[objective_index] <= value;
      nadir_r[objective_index] <= second_value;
    end
    if (in_acc && mode == MODE_COORD)
      point_r[objective_index] <= value;
    if (state == ST_NORM && span == '0)
      norm_r[oi] <= norm_zero;
    else if (state == ST_DIV && div_done)
      norm_r[oi] <= norm_sat;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rm_valid   <= '0;
      point_seen <= 1'b0;
      out_valid  <= 1'b0;
      oi         <= '0;
      wi         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (mode)
              MODE_COORD: begin
                if (objective_index == obj_last) begin
                  oi    <= '0;
                  state <= ST_NORM;
                end
              end
              MODE_CLEAR: begin
                rm_valid   <= '0;
                point_seen <= 1'b0;
              end
              MODE_EMIT: begin
                wi    <= '0;
                state <= ST_ERD;
              end
              default: ;
            endcase
          end
        end
        ST_NORM, ST_DIV: begin
          if (state == ST_NORM && span != '0) begin
            state <= ST_DIV;
          end else if (state == ST_NORM || div_done) begin
            if (oi == obj_last) begin
              oi    <= '0;
              wi    <= '0;
              sum   <= '0;
              mx    <= '0;
              state <= ST_WRD;
            end else begin
              oi    <= oi + 1'b1;
              state <= ST_NORM;
            end
          end
        end
        ST_WRD: state <= ST_MUL;
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          sum <= sum + 36'(term);
          if (term > mx)
            mx <= term;
          if (oi == obj_last) begin
            state <= ST_RHO;
          end else begin
            oi    <= oi + 1'b1;
            state <= ST_WRD;
          end
        end
        ST_RHO: state <= ST_UPD;
        ST_UPD: begin
          if (u_sat > rm_cur)
            rm_valid[wi] <= 1'b1;
          oi  <= '0;
          sum <= '0;
          mx  <= '0;
          if (wi == vec_last) begin
            point_seen <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            wi    <= wi + 1'b1;
            state <= ST_WRD;
          end
        end
        ST_ERD: state <= ST_ESEND;
        ST_ESEND: begin
          out_valid    <= 1'b1;
          out_vector   <= wi;
          best_utility <= rm_cur;
          any_point    <= point_seen;
          last         <= (wi == vec_last);
          state        <= ST_EHOLD;
        end
        ST_EHOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (wi == vec_last) begin
              state <= ST_IDLE;
            end else begin
              wi    <= wi + 1'b1;
              state <= ST_ERD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rim_div.sv =====
// ----------------------------------------------------------------------------
// rim_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rim_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rim_pkg::DVD_W-1:0]  dividend,
  input  logic [rim_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [rim_pkg::DVD_W-1:0]  quotient
);
  import rim_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     rem;
  logic [DVD_W-1:0]     quo;
  logic [DVS_W:0]       rem_sh;
  logic                 ge;

  // trial subtract of the shifted remainder
  assign rem_sh   = {rem, quo[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : DVS_W'(rem_sh);
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

// ===== sv/rim_mul.sv =====
// ----------------------------------------------------------------------------
// rim_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rim_mul (
  input  logic                             clk,
  input  logic signed [rim_pkg::MA_W-1:0]  a,
  input  logic signed [rim_pkg::MB_W-1:0]  b,
  output logic signed [rim_pkg::MP_W-1:0]  prod
);
  import rim_pkg::*;

  // register the product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
